### src/rrpc_pkg.sv
// shared types, codes and compare helpers for the range predicate check unit
package rrpc_pkg;

  typedef enum logic [3:0] {
    OP_FALSE = 4'd0, OP_TRUE = 4'd1, OP_ISNULL = 4'd2, OP_NOTNULL = 4'd3,
    OP_EQ = 4'd4, OP_NE = 4'd5, OP_LT = 4'd6, OP_LE = 4'd7, OP_GT = 4'd8,
    OP_GE = 4'd9, OP_BETWEEN = 4'd10, OP_NOTBETWEEN = 4'd11, OP_LIKE = 4'd12,
    OP_NOTLIKE = 4'd13, OP_OTHER = 4'd14, OP_SPARE = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    V_NONE = 2'd0, V_SOME = 2'd1, V_ALL = 2'd2, V_BAD = 2'd3
  } verdict_t;

  localparam logic [1:0] REG_FLOAT_MODE = 2'd0;
  localparam logic [1:0] REG_NULL_CODE = 2'd1;
  localparam logic [1:0] REG_MINUS_INF = 2'd2;
  localparam logic [1:0] REG_PLUS_INF = 2'd3;

  localparam logic [63:0] DBL_MINUS_INF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] DBL_PLUS_INF = 64'h7FF0_0000_0000_0000;

  typedef struct packed {
    logic        float_mode;
    logic [63:0] null_code;
    logic [63:0] minus_inf_code;
    logic [63:0] plus_inf_code;
  } cfg_t;

  // compare results: lt, le, eq
  typedef struct packed {
    logic lt;
    logic le;
    logic eq;
  } cmp_t;

  function automatic cmp_t cmp_words(input logic [63:0] a, input logic [63:0] b,
                                     input logic fmode);
    cmp_t r;
    logic a_nan, b_nan, a_zero, b_zero, mag_lt, s_lt;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    mag_lt = a[62:0] < b[62:0];
    s_lt = $signed(a) < $signed(b);
    if (fmode) begin
      if (a_nan || b_nan) begin
        r = '0;
      end else begin
        r.eq = (a == b) || (a_zero && b_zero);
        if (a_zero && b_zero) r.lt = 1'b0;
        else if (a[63] != b[63]) r.lt = a[63];
        else if (a[63]) r.lt = (b[62:0] < a[62:0]);
        else r.lt = mag_lt;
        r.le = r.lt || r.eq;
      end
    end else begin
      r.lt = s_lt;
      r.eq = (a == b);
      r.le = s_lt || r.eq;
    end
    return r;
  endfunction

endpackage

### src/rough_range_predicate_check_unit.sv
// top level of the zone-map range predicate check unit
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | req_type, stats, operand and null flags
// out     | out_valid / out_ready| verdict
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle while out_ready does not stall; input register, then the
// verdict logic (five 64-bit compares) into the output register
// in_ready stays high while the output register is empty or being drained
// synchronous reset clears the valid flags and loads the register defaults
module rough_range_predicate_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic [63:0] pack_min,
  input  logic [63:0] pack_max,
  input  logic [63:0] first_min,
  input  logic [63:0] first_max,
  input  logic [63:0] second_min,
  input  logic [63:0] second_max,
  input  logic [5:0]  operand_flags,
  input  logic [2:0]  nulls_possible_flags,
  input  logic [2:0]  all_null_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rrpc_pkg::*;

  cfg_t cfg;
  // input register stage
  logic        s1_valid;
  logic [3:0]  s1_type;
  logic [63:0] s1_amin, s1_amax, s1_v1min, s1_v1max, s1_v2min, s1_v2max;
  logic [5:0]  s1_of;
  logic [2:0]  s1_np, s1_an;
  logic [1:0]  s1_verdict;
  logic        s1_ready;

  rrpc_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  rrpc_decide u_decide (
    .cfg(cfg), .req_type(s1_type), .pack_min(s1_amin), .pack_max(s1_amax),
    .first_min(s1_v1min), .first_max(s1_v1max), .second_min(s1_v2min),
    .second_max(s1_v2max), .operand_flags(s1_of), .nulls_possible_flags(s1_np),
    .all_null_flags(s1_an), .verdict(s1_verdict)
  );

  // stage 1 advances when the output register is free or draining
  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_type <= req_type;
      s1_amin <= pack_min;
      s1_amax <= pack_max;
      s1_v1min <= first_min;
      s1_v1max <= first_max;
      s1_v2min <= second_min;
      s1_v2max <= second_max;
      s1_of <= operand_flags;
      s1_np <= nulls_possible_flags;
      s1_an <= all_null_flags;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
    if (s1_ready && s1_valid) verdict <= s1_verdict;
  end
endmodule

### src/rrpc_cfg_regs.sv
// configuration register file
module rrpc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output rrpc_pkg::cfg_t      cfg
);
  import rrpc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.float_mode <= 1'b0;
      cfg.null_code <= 64'h8000_0000_0000_0000;
      cfg.minus_inf_code <= 64'h8000_0000_0000_0001;
      cfg.plus_inf_code <= 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FLOAT_MODE: cfg.float_mode <= cfg_data[0];
        REG_NULL_CODE:  cfg.null_code <= cfg_data;
        REG_MINUS_INF:  cfg.minus_inf_code <= cfg_data;
        REG_PLUS_INF:   cfg.plus_inf_code <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

### src/rrpc_decide.sv
// combinational verdict logic for one registered word
module rrpc_decide (
  input  rrpc_pkg::cfg_t   cfg,
  input  logic [3:0]       req_type,
  input  logic [63:0]      pack_min,
  input  logic [63:0]      pack_max,
  input  logic [63:0]      first_min,
  input  logic [63:0]      first_max,
  input  logic [63:0]      second_min,
  input  logic [63:0]      second_max,
  input  logic [5:0]       operand_flags,
  input  logic [2:0]       nulls_possible_flags,
  input  logic [2:0]       all_null_flags,
  output logic [1:0]       verdict
);
  import rrpc_pkg::*;

  logic p1, p2, m1, m2, c1, c2, btw, inv, fm;
  logic [63:0] amin, amax, v1min, v1max, v2min, v2max;
  cmp_t c_v1max_amin, c_amax_v2min, c_v2max_amin, c_amax_v1min, c_amin_v1max;
  verdict_t res, r0;
  op_t op;

  assign op = op_t'(req_type);
  assign p1 = operand_flags[0];
  assign p2 = operand_flags[1];
  assign m1 = operand_flags[2];
  assign m2 = operand_flags[3];
  assign c1 = operand_flags[4];
  assign c2 = operand_flags[5];
  assign fm = cfg.float_mode;
  assign btw = (op == OP_BETWEEN) || (op == OP_NOTBETWEEN);
  assign inv = (op == OP_NE) || (op == OP_LE) || (op == OP_GE) || (op == OP_NOTBETWEEN);

  // sentinel substitution in float mode
  assign amin = (fm && pack_min == cfg.minus_inf_code) ? DBL_MINUS_INF : pack_min;
  assign v1min = (fm && first_min == cfg.minus_inf_code) ? DBL_MINUS_INF : first_min;
  assign v2min = (fm && second_min == cfg.minus_inf_code) ? DBL_MINUS_INF : second_min;
  assign amax = (fm && pack_max == cfg.plus_inf_code) ? DBL_PLUS_INF : pack_max;
  assign v1max = (fm && first_max == cfg.plus_inf_code) ? DBL_PLUS_INF : first_max;
  assign v2max = (fm && second_max == cfg.plus_inf_code) ? DBL_PLUS_INF : second_max;

  assign c_v1max_amin = cmp_words(v1max, amin, fm);
  assign c_amax_v2min = cmp_words(amax, v2min, fm);
  assign c_v2max_amin = cmp_words(v2max, amin, fm);
  assign c_amax_v1min = cmp_words(amax, v1min, fm);
  assign c_amin_v1max = cmp_words(amin, v1max, fm);

  // range verdict before inversion
  always_comb begin
    r0 = V_SOME;
    if (btw) begin
      if (c_v1max_amin.le && c_amax_v2min.le) r0 = V_ALL;
      else if (c_v2max_amin.lt || c_amax_v1min.lt) r0 = V_NONE;
    end else begin
      if (c_v1max_amin.le) begin
        if (op == OP_LT || op == OP_GE) r0 = V_NONE;
        if (c_v1max_amin.lt) begin
          if (op == OP_EQ || op == OP_NE) r0 = V_NONE;
          if (op == OP_GT || op == OP_LE) r0 = V_ALL;
        end
      end
      if (c_amax_v1min.le) begin
        if (op == OP_GT || op == OP_LE) r0 = V_NONE;
        if (c_amax_v1min.lt) begin
          if (op == OP_EQ || op == OP_NE) r0 = V_NONE;
          if (op == OP_LT || op == OP_GE) r0 = V_ALL;
        end
      end
      if (r0 == V_SOME && (op == OP_EQ || op == OP_NE) && c_amin_v1max.eq &&
          c_amax_v1min.eq) r0 = V_ALL;
    end
  end

  always_comb begin
    res = V_SOME;
    if (op == OP_FALSE) res = V_NONE;
    else if (op == OP_TRUE) res = V_ALL;
    else if (op == OP_ISNULL || op == OP_NOTNULL) begin
      if (all_null_flags[0]) res = (op == OP_ISNULL) ? V_ALL : V_NONE;
      else if (!nulls_possible_flags[0]) res = (op == OP_ISNULL) ? V_NONE : V_ALL;
      else res = V_SOME;
    end else if (!p1 || (btw && !p2)) res = V_SOME;
    else if (all_null_flags[0] || (!m1 && (all_null_flags[1] ||
             (p2 && !m2 && all_null_flags[2])))) res = V_NONE;
    else if (op == OP_LIKE || op == OP_NOTLIKE || m1 || (p2 && m2)) res = V_SOME;
    else if (!c1 || (btw && !c2)) res = V_SOME;
    else if (pack_min == cfg.null_code || pack_max == cfg.null_code ||
             first_min == cfg.null_code || first_max == cfg.null_code ||
             (p2 && (second_min == cfg.null_code || second_max == cfg.null_code)))
      res = V_SOME;
    else if (op == OP_OTHER || op == OP_SPARE) res = V_SOME;
    else begin
      res = r0;
      if (inv) begin
        if (r0 == V_ALL) res = V_NONE;
        else if (r0 == V_NONE) res = V_ALL;
      end
      if (res == V_ALL && (nulls_possible_flags[0] || nulls_possible_flags[1] ||
          (p2 && nulls_possible_flags[2]))) res = V_SOME;
    end
  end

  assign verdict = res;
endmodule

### src/rrpc_checker.sv
// port-level checks for the range predicate check unit, bound to the top level
module rrpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] verdict,
  input logic       cfg_ready
);
  import rrpc_pkg::*;

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict != V_BAD) else $error("verdict code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("result word dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("config port stalled");
endmodule

bind rough_range_predicate_check_unit rrpc_checker u_rrpc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .verdict(verdict),
  .cfg_ready(cfg_ready)
);

### dv/tb_top.sv
// testbench for the range predicate check unit: directed and random words checked
// against a local verdict predictor
`timescale 1ns / 1ps

module tb_top;
  import rrpc_pkg::*;

  // kinds of statistic comparison used by the predictor
  typedef enum int {STAT_LT, STAT_LE, STAT_EQ} stat_cmp_t;

  typedef struct {
    op_t         op;
    logic [63:0] pmin, pmax, amin, amax, bmin, bmax;
    logic [5:0]  oflags;
    logic [2:0]  nflags;
    logic [2:0]  aflags;
  } pred_word_t;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [3:0]  req_type;
  logic [63:0] pack_min, pack_max, first_min, first_max, second_min, second_max;
  logic [5:0]  operand_flags;
  logic [2:0]  nulls_possible_flags, all_null_flags;
  logic [1:0]  verdict;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // shadow copy of the block's registers, as seen by the predictor
  cfg_t     shadow_cfg;
  verdict_t expected_verdicts[$];
  int       error_count;
  bit       idle_on;
  int       rx_hold_cycles;
  int       stall_cycles;

  rough_range_predicate_check_unit dut (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // word as an ieee double, with the infinity sentinels swapped in
  function automatic real stat_real(logic [63:0] w, bit is_min);
    logic [63:0] bits;
    bits = w;
    if (is_min && w == shadow_cfg.minus_inf_code) bits = 64'hFFF0_0000_0000_0000;
    if (!is_min && w == shadow_cfg.plus_inf_code) bits = 64'h7FF0_0000_0000_0000;
    return $bitstoreal(bits);
  endfunction

  function automatic bit stat_cmp(logic [63:0] a, bit a_min, logic [63:0] b, bit b_min,
                                  stat_cmp_t kind);
    real x, y;
    if (shadow_cfg.float_mode) begin
      x = stat_real(a, a_min);
      y = stat_real(b, b_min);
      case (kind)
        STAT_LT: return x < y;
        STAT_LE: return x <= y;
        default: return x == y;
      endcase
    end
    case (kind)
      STAT_LT: return $signed(a) < $signed(b);
      STAT_LE: return $signed(a) <= $signed(b);
      default: return a == b;
    endcase
  endfunction

  function automatic verdict_t predict_verdict(pred_word_t w);
    bit p1, p2, m1, m2, c1, c2, btw, nul;
    logic [63:0] nc;
    verdict_t res;
    p1 = w.oflags[0]; p2 = w.oflags[1]; m1 = w.oflags[2];
    m2 = w.oflags[3]; c1 = w.oflags[4]; c2 = w.oflags[5];
    btw = (w.op == OP_BETWEEN || w.op == OP_NOTBETWEEN);
    nc = shadow_cfg.null_code;
    res = V_SOME;
    if (w.op == OP_FALSE) return V_NONE;
    if (w.op == OP_TRUE) return V_ALL;
    if (w.op == OP_ISNULL || w.op == OP_NOTNULL) begin
      if (w.aflags[0]) return (w.op == OP_ISNULL) ? V_ALL : V_NONE;
      if (!w.nflags[0]) return (w.op == OP_ISNULL) ? V_NONE : V_ALL;
      return V_SOME;
    end
    // irregular operands
    if (!p1 || (btw && !p2)) return V_SOME;
    // all-null column or operands
    if (w.aflags[0] || (!m1 && (w.aflags[1] || (p2 && !m2 && w.aflags[2]))))
      return V_NONE;
    if (w.op == OP_LIKE || w.op == OP_NOTLIKE || m1 || (p2 && m2)) return V_SOME;
    if (!c1 || (btw && !c2)) return V_SOME;
    // unknown statistics; second operand only counts when present
    nul = (w.pmin == nc) || (w.pmax == nc) || (w.amin == nc) || (w.amax == nc) ||
          (p2 && (w.bmin == nc || w.bmax == nc));
    if (nul) return V_SOME;

    if (btw) begin
      if (stat_cmp(w.amax, 0, w.pmin, 1, STAT_LE) && stat_cmp(w.pmax, 0, w.bmin, 1, STAT_LE))
        res = V_ALL;
      else if (stat_cmp(w.bmax, 0, w.pmin, 1, STAT_LT) ||
               stat_cmp(w.pmax, 0, w.amin, 1, STAT_LT))
        res = V_NONE;
    end else begin
      if (stat_cmp(w.amax, 0, w.pmin, 1, STAT_LE)) begin
        if (w.op == OP_LT || w.op == OP_GE) res = V_NONE;
        if (stat_cmp(w.amax, 0, w.pmin, 1, STAT_LT)) begin
          if (w.op == OP_EQ || w.op == OP_NE) res = V_NONE;
          if (w.op == OP_GT || w.op == OP_LE) res = V_ALL;
        end
      end
      if (stat_cmp(w.pmax, 0, w.amin, 1, STAT_LE)) begin
        if (w.op == OP_GT || w.op == OP_LE) res = V_NONE;
        if (stat_cmp(w.pmax, 0, w.amin, 1, STAT_LT)) begin
          if (w.op == OP_EQ || w.op == OP_NE) res = V_NONE;
          if (w.op == OP_LT || w.op == OP_GE) res = V_ALL;
        end
      end
      // single-valued pack equal to single-valued operand
      if (res == V_SOME && (w.op == OP_EQ || w.op == OP_NE) &&
          stat_cmp(w.pmin, 1, w.amax, 0, STAT_EQ) && stat_cmp(w.pmax, 0, w.amin, 1, STAT_EQ))
        res = V_ALL;
    end

    // negated operators flip the positive verdict
    if (w.op == OP_NE || w.op == OP_LE || w.op == OP_GE || w.op == OP_NOTBETWEEN) begin
      if (res == V_ALL) res = V_NONE;
      else if (res == V_NONE) res = V_ALL;
    end
    // possible nulls demote all to some
    if (res == V_ALL && (w.nflags[0] || w.nflags[1] || (p2 && w.nflags[2]))) res = V_SOME;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver: checks each accepted word, drives out_ready with stall bursts
  initial begin
    verdict_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected word", verdict, -1);
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict !== want) report_mismatch("verdict", verdict, want);
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_cycles = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no handshake on any channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= 4000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_word(pred_word_t w);
    req_type <= w.op;
    pack_min <= w.pmin;  pack_max <= w.pmax;
    first_min <= w.amin; first_max <= w.amax;
    second_min <= w.bmin; second_max <= w.bmax;
    operand_flags <= w.oflags;
    nulls_possible_flags <= w.nflags;
    all_null_flags <= w.aflags;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_verdicts.push_back(predict_verdict(w));
    // random gap before the next word
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write between phases, block idle
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FLOAT_MODE: shadow_cfg.float_mode = val[0];
      REG_NULL_CODE:  shadow_cfg.null_code = val;
      REG_MINUS_INF:  shadow_cfg.minus_inf_code = val;
      default:        shadow_cfg.plus_inf_code = val;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [63:0] rand_stat();
    case ($urandom_range(0, 11))
      0: return shadow_cfg.null_code;
      1: return shadow_cfg.minus_inf_code;
      2: return shadow_cfg.plus_inf_code;
      3: return {$urandom, $urandom};
      4: return 64'h8000_0000_0000_0000;
      5: return 64'h7FFF_FFFF_FFFF_FFFF;
      6: return 64'h7FF8_0000_0000_0001;          // nan
      7: return $urandom_range(0, 1) ? 64'h0 : 64'h8000_0000_0000_0000;
      default: begin
        if (shadow_cfg.float_mode)
          return $realtobits(real'($urandom_range(0, 40)) / 2.0 - 10.0);
        return 64'($signed($urandom_range(0, 40)) - 20);
      end
    endcase
  endfunction

  function automatic pred_word_t rand_word();
    pred_word_t w;
    w.op = op_t'($urandom_range(0, 15));
    w.pmin = rand_stat(); w.pmax = rand_stat();
    w.amin = rand_stat(); w.amax = rand_stat();
    w.bmin = rand_stat(); w.bmax = rand_stat();
    if ($urandom_range(0, 4) != 0) begin
      // well-formed: operands present and comparable, rarely multivalued
      w.oflags = 6'b110011;
      if ($urandom_range(0, 9) == 0) w.oflags[3:2] = 2'($urandom);
      if ($urandom_range(0, 9) == 0) w.oflags[1] = 1'b0;
      w.nflags = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
      w.aflags = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b000;
    end else begin
      w.oflags = 6'($urandom);
      w.nflags = 3'($urandom);
      w.aflags = 3'($urandom);
    end
    return w;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_word(rand_word());
  endtask

  // every operator on a plain item, then field extremes and special cases
  task automatic test_directed;
    pred_word_t w;
    w = '{OP_FALSE, 64'd10, 64'd20, 64'd15, 64'd15, 64'd18, 64'd18, 6'b110011, 3'b0, 3'b0};
    for (int i = 0; i < 16; i++) begin
      w.op = op_t'(i);
      send_word(w);
    end
    w.op = OP_EQ;                                   // single-valued pack equal to operand
    w.pmin = 64'd5; w.pmax = 64'd5; w.amin = 64'd5; w.amax = 64'd5;
    send_word(w);
    w.pmin = 64'h8000_0000_0000_0000;               // unknown statistic
    send_word(w);
    w = '{OP_BETWEEN, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
          64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
          64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 6'b111111, 3'b111, 3'b111};
    send_word(w);
    w.oflags = 6'b110011; w.aflags = 3'b010;        // all-null first operand
    send_word(w);
    w.aflags = 3'b000; w.nflags = 3'b000; w.op = OP_NOTBETWEEN;
    send_word(w);
    w.oflags = 6'b000000;                           // missing operand
    send_word(w);
    w = '{OP_ISNULL, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 6'h00, 3'b001, 3'b000};
    send_word(w);
    w.op = OP_NOTNULL; w.nflags = 3'b000;
    send_word(w);
  endtask

  task automatic test_int_mode;
    write_reg(REG_FLOAT_MODE, 64'd0);
    send_random(500);
  endtask

  task automatic test_float_mode;
    write_reg(REG_FLOAT_MODE, 64'd1);
    send_random(400);
    // sentinels moved onto ordinary values and the extremes
    write_reg(REG_NULL_CODE, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_MINUS_INF, 64'h8000_0000_0000_0000);
    write_reg(REG_PLUS_INF, $realtobits(5.0));
    send_random(300);
    write_reg(REG_NULL_CODE, 64'd0);
    write_reg(REG_MINUS_INF, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PLUS_INF, 64'h0);
    send_random(200);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure;
    write_reg(REG_FLOAT_MODE, 64'd0);
    write_reg(REG_NULL_CODE, 64'h8000_0000_0000_0000);
    rx_hold_cycles = 80;
    send_random(300);
  endtask

  // last stretch with no idling at all
  task automatic test_full_rate;
    idle_on = 0;
    send_random(300);
  endtask

  initial begin
    rst = 1'b1;
    in_valid <= 1'b0; cfg_valid <= 1'b0;
    req_type <= '0; pack_min <= '0; pack_max <= '0; first_min <= '0; first_max <= '0;
    second_min <= '0; second_max <= '0; operand_flags <= '0;
    nulls_possible_flags <= '0; all_null_flags <= '0;
    cfg_index <= '0; cfg_data <= '0;
    shadow_cfg = '{1'b0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                   64'h7FFF_FFFF_FFFF_FFFF};
    error_count = 0;
    rx_hold_cycles = 0;
    stall_cycles = 0;
    idle_on = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_int_mode();
    test_float_mode();
    test_backpressure();
    test_full_rate();

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### files.f
src/rrpc_pkg.sv
src/rrpc_cfg_regs.sv
src/rrpc_decide.sv
src/rough_range_predicate_check_unit.sv
src/rrpc_checker.sv
dv/tb_top.sv
